FILE: rtl/tile_pixel_render_2bpp_top_defines.svh
// ----------------------------------------------------------------------------
// Tile pixel render assertion macros
// Shared concurrent assertion forms for the tile pixel render checkers.
// ----------------------------------------------------------------------------
`ifndef TILE_PIXEL_RENDER_2BPP_TOP_DEFINES_SVH
`define TILE_PIXEL_RENDER_2BPP_TOP_DEFINES_SVH

// same-cycle implication, masked during reset
`define TPR_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tile pixel render check failed");

// next-cycle implication, masked during reset
`define TPR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tile pixel render check failed");

// next-cycle implication, live during reset
`define TPR_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("tile pixel render check failed");

`endif

FILE: rtl/tpr_pkg.sv
// ----------------------------------------------------------------------------
// Tile pixel render package
// Field widths, register codes, reset values and tile size helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpr_pkg;

   localparam int TILE_SIZE_W   = 5;
   localparam int SCREEN_W      = 13;
   localparam int DATA_W        = 8;
   localparam int ROW_W         = 4;
   localparam int GROUP_W       = 2;
   localparam int RGB_W         = 24;
   localparam int COLOR_W       = 32;
   localparam int NUM_COLORS    = 4;
   localparam int PIX_PER_ITEM  = 4;
   localparam int CNT_W         = 3;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int MAX_TILE_SIZE = 16;
   localparam int COORD_BITS_DEF = 12;

   localparam logic [TILE_SIZE_W-1:0] TILE_SIZE_RST     = TILE_SIZE_W'(8);
   localparam logic [SCREEN_W-1:0]    SCREEN_WIDTH_RST  = SCREEN_W'(256);
   localparam logic [SCREEN_W-1:0]    SCREEN_HEIGHT_RST = SCREEN_W'(224);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TILE_SIZE     = 3'd0,
      CSR_SCREEN_WIDTH  = 3'd1,
      CSR_SCREEN_HEIGHT = 3'd2,
      CSR_PALETTE_0     = 3'd3,
      CSR_PALETTE_1     = 3'd4,
      CSR_PALETTE_2     = 3'd5,
      CSR_PALETTE_3     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [TILE_SIZE_W-1:0]                size_code;
      logic [SCREEN_W-1:0]                   screen_width;
      logic [SCREEN_W-1:0]                   screen_height;
      logic [NUM_COLORS-1:0][COLOR_W-1:0]    palette;
   } cfg_type;

   // round down to a multiple of four, clamp, zero counts as four
   function automatic logic [TILE_SIZE_W-1:0] eff_size(input logic [TILE_SIZE_W-1:0] ts);
      logic [TILE_SIZE_W-1:0] s;
      s = ts & TILE_SIZE_W'(5'h1C);
      if (s > TILE_SIZE_W'(MAX_TILE_SIZE)) begin
         s = TILE_SIZE_W'(MAX_TILE_SIZE) & ~TILE_SIZE_W'(3);
      end
      if (s == '0) begin
         s = TILE_SIZE_W'(4);
      end
      return s;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/tile_pixel_render_2bpp_top.sv
// ----------------------------------------------------------------------------
// Tile pixel render, 2 bits per pixel
// Turns packed tile bytes into flipped, clipped, palette-colored pixel writes.
//
//   channel | direction | handshake          | content
//   req_    | in        | valid / stall      | one tile byte with draw settings
//   rsp_    | out       | valid / stall      | one pixel write, last on final
//   csr_    | in        | valid / ready      | register index and write data
//
// An accepted item is held in the input register and evaluated in one pass;
// its writes are loaded into the result queue and leave on rsp_ one write per
// cycle while rsp_stall is low. The queue takes the next item as the last write
// of the current one leaves, so the result port sets the item rate.
// reset is synchronous, clears all valid state and restores register defaults.
// rsp_stall holds the head write; req_stall rises while the input register
// is full and the result queue cannot take its item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tile_pixel_render_2bpp_top #(
   parameter int COORD_BITS = tpr_pkg::COORD_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [tpr_pkg::DATA_W-1:0]      req_data_byte,
   input  wire logic [tpr_pkg::ROW_W-1:0]       req_tile_row,
   input  wire logic [tpr_pkg::GROUP_W-1:0]     req_column_group,
   input  wire logic [COORD_BITS-1:0]           req_tile_x,
   input  wire logic [COORD_BITS-1:0]           req_tile_y,
   input  wire logic                            req_flip_x,
   input  wire logic                            req_flip_y,
   input  wire logic                            req_mask_enable,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [COORD_BITS-1:0]                rsp_pixel_x,
   output logic [COORD_BITS-1:0]                rsp_pixel_y,
   output logic [tpr_pkg::RGB_W-1:0]            rsp_pixel_rgb,
   output logic                                 rsp_last,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [tpr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tpr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tpr_pkg::*;

   cfg_type                                cfg;
   logic                                   a_valid_ff;
   logic                                   a_valid_in;
   logic [DATA_W-1:0]                      data_byte_ff;
   logic [ROW_W-1:0]                       tile_row_ff;
   logic [GROUP_W-1:0]                     column_group_ff;
   logic [COORD_BITS-1:0]                  tile_x_ff;
   logic [COORD_BITS-1:0]                  tile_y_ff;
   logic                                   flip_x_ff;
   logic                                   flip_y_ff;
   logic                                   mask_enable_ff;
   logic                                   req_accept;
   logic                                   q_ready;
   logic                                   q_load;
   logic [CNT_W-1:0]                       burst_cnt;
   logic [PIX_PER_ITEM-1:0][COORD_BITS-1:0] burst_x;
   logic [PIX_PER_ITEM-1:0][COORD_BITS-1:0] burst_y;
   logic [PIX_PER_ITEM-1:0][RGB_W-1:0]     burst_rgb;

   tpr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign q_load     = a_valid_ff & q_ready;
   assign req_stall  = a_valid_ff & ~q_ready;
   assign req_accept = req_valid & ~req_stall;
   assign a_valid_in = req_accept | (a_valid_ff & ~q_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         data_byte_ff    <= req_data_byte;
         tile_row_ff     <= req_tile_row;
         column_group_ff <= req_column_group;
         tile_x_ff       <= req_tile_x;
         tile_y_ff       <= req_tile_y;
         flip_x_ff       <= req_flip_x;
         flip_y_ff       <= req_flip_y;
         mask_enable_ff  <= req_mask_enable;
      end
   end

   tpr_pixel_eval #(
      .COORD_BITS (COORD_BITS)
   ) u_eval (
      .cfg          (cfg),
      .data_byte    (data_byte_ff),
      .tile_row     (tile_row_ff),
      .column_group (column_group_ff),
      .tile_x       (tile_x_ff),
      .tile_y       (tile_y_ff),
      .flip_x       (flip_x_ff),
      .flip_y       (flip_y_ff),
      .mask_enable  (mask_enable_ff),
      .burst_cnt    (burst_cnt),
      .burst_x      (burst_x),
      .burst_y      (burst_y),
      .burst_rgb    (burst_rgb)
   );

   tpr_burst_queue #(
      .COORD_BITS (COORD_BITS)
   ) u_queue (
      .clock         (clock),
      .reset         (reset),
      .load          (q_load),
      .ready         (q_ready),
      .in_cnt        (burst_cnt),
      .in_x          (burst_x),
      .in_y          (burst_y),
      .in_rgb        (burst_rgb),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_x   (rsp_pixel_x),
      .rsp_pixel_y   (rsp_pixel_y),
      .rsp_pixel_rgb (rsp_pixel_rgb),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire

FILE: rtl/tpr_csr.sv
// ----------------------------------------------------------------------------
// Tile pixel render registers
// Holds tile size, screen clip limits and the four palette entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpr_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [tpr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tpr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output tpr_pkg::cfg_type                    cfg
);
   import tpr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid & csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (csr_index_type'(csr_index))
            CSR_TILE_SIZE:     cfg_in.size_code     = csr_wdata[TILE_SIZE_W-1:0];
            CSR_SCREEN_WIDTH:  cfg_in.screen_width  = csr_wdata[SCREEN_W-1:0];
            CSR_SCREEN_HEIGHT: cfg_in.screen_height = csr_wdata[SCREEN_W-1:0];
            CSR_PALETTE_0:     cfg_in.palette[0]    = csr_wdata[COLOR_W-1:0];
            CSR_PALETTE_1:     cfg_in.palette[1]    = csr_wdata[COLOR_W-1:0];
            CSR_PALETTE_2:     cfg_in.palette[2]    = csr_wdata[COLOR_W-1:0];
            CSR_PALETTE_3:     cfg_in.palette[3]    = csr_wdata[COLOR_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.size_code     <= TILE_SIZE_RST;
         cfg_ff.screen_width  <= SCREEN_WIDTH_RST;
         cfg_ff.screen_height <= SCREEN_HEIGHT_RST;
         cfg_ff.palette       <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/tpr_pixel_eval.sv
// ----------------------------------------------------------------------------
// Tile pixel render evaluation
// Maps one held item to up to four clipped, colored pixel writes, packed low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpr_pixel_eval #(
   parameter int COORD_BITS = tpr_pkg::COORD_BITS_DEF
) (
   input  wire tpr_pkg::cfg_type                                    cfg,
   input  wire logic [tpr_pkg::DATA_W-1:0]                           data_byte,
   input  wire logic [tpr_pkg::ROW_W-1:0]                            tile_row,
   input  wire logic [tpr_pkg::GROUP_W-1:0]                          column_group,
   input  wire logic [COORD_BITS-1:0]                                tile_x,
   input  wire logic [COORD_BITS-1:0]                                tile_y,
   input  wire logic                                                 flip_x,
   input  wire logic                                                 flip_y,
   input  wire logic                                                 mask_enable,
   output logic [tpr_pkg::CNT_W-1:0]                                 burst_cnt,
   output logic [tpr_pkg::PIX_PER_ITEM-1:0][COORD_BITS-1:0]          burst_x,
   output logic [tpr_pkg::PIX_PER_ITEM-1:0][COORD_BITS-1:0]          burst_y,
   output logic [tpr_pkg::PIX_PER_ITEM-1:0][tpr_pkg::RGB_W-1:0]      burst_rgb
);
   import tpr_pkg::*;

   localparam int CMP_W = (COORD_BITS + 1 > SCREEN_W) ? COORD_BITS + 1 : SCREEN_W;

   logic [TILE_SIZE_W-1:0]                  size;
   logic [CMP_W-1:0]                        size_e;
   logic [CMP_W-1:0]                        tx_e;
   logic [CMP_W-1:0]                        ty_e;
   logic [CMP_W-1:0]                        sw_e;
   logic [CMP_W-1:0]                        sh_e;
   logic [CMP_W-1:0]                        yy;
   logic                                    row_ok;
   logic                                    item_ok;
   logic [PIX_PER_ITEM-1:0][CMP_W-1:0]      xx;
   logic [PIX_PER_ITEM-1:0][COLOR_W-1:0]    col;
   logic [PIX_PER_ITEM-1:0]                 keep;

   assign size   = eff_size(cfg.size_code);
   assign size_e = CMP_W'(size);
   assign tx_e   = CMP_W'(tile_x);
   assign ty_e   = CMP_W'(tile_y);
   assign sw_e   = CMP_W'(cfg.screen_width);
   assign sh_e   = CMP_W'(cfg.screen_height);

   assign yy = flip_y ? ty_e + size_e - CMP_W'(tile_row) - CMP_W'(1)
                      : ty_e + CMP_W'(tile_row);

   assign row_ok = (TILE_SIZE_W'(tile_row) < size)
                 && (TILE_SIZE_W'({column_group, 2'b00}) < size);

   assign item_ok = row_ok && (tx_e < sw_e) && (ty_e < sh_e) && (yy < sh_e)
                 && (yy[CMP_W-1:COORD_BITS] == '0);

   always_comb begin
      for (int k = 0; k < PIX_PER_ITEM; k++) begin
         xx[k]   = flip_x ? tx_e + size_e - CMP_W'({column_group, 2'(k)}) - CMP_W'(1)
                          : tx_e + CMP_W'({column_group, 2'(k)});
         col[k]  = cfg.palette[{data_byte[7 - k], data_byte[3 - k]}];
         keep[k] = item_ok && (xx[k] < sw_e) && (xx[k][CMP_W-1:COORD_BITS] == '0)
                 && !(mask_enable && (col[k][COLOR_W-1:RGB_W] == '0));
      end
   end

   // pack survivors into the low slots, in column order
   always_comb begin
      logic [CNT_W-1:0] slot;
      slot      = '0;
      burst_x   = '0;
      burst_y   = '0;
      burst_rgb = '0;
      for (int k = 0; k < PIX_PER_ITEM; k++) begin
         if (keep[k]) begin
            burst_x[slot[1:0]]   = xx[k][COORD_BITS-1:0];
            burst_y[slot[1:0]]   = yy[COORD_BITS-1:0];
            burst_rgb[slot[1:0]] = col[k][RGB_W-1:0];
            slot = slot + CNT_W'(1);
         end
      end
      burst_cnt = slot;
   end

endmodule

`default_nettype wire

FILE: rtl/tpr_burst_queue.sv
// ----------------------------------------------------------------------------
// Tile pixel render result queue
// Holds the pixel writes of one item and hands them out one per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpr_burst_queue #(
   parameter int COORD_BITS = tpr_pkg::COORD_BITS_DEF
) (
   input  wire logic                                                 clock,
   input  wire logic                                                 reset,
   input  wire logic                                                 load,
   output logic                                                      ready,
   input  wire logic [tpr_pkg::CNT_W-1:0]                            in_cnt,
   input  wire logic [tpr_pkg::PIX_PER_ITEM-1:0][COORD_BITS-1:0]     in_x,
   input  wire logic [tpr_pkg::PIX_PER_ITEM-1:0][COORD_BITS-1:0]     in_y,
   input  wire logic [tpr_pkg::PIX_PER_ITEM-1:0][tpr_pkg::RGB_W-1:0] in_rgb,
   output logic                                                      rsp_valid,
   input  wire logic                                                 rsp_stall,
   output logic [COORD_BITS-1:0]                                     rsp_pixel_x,
   output logic [COORD_BITS-1:0]                                     rsp_pixel_y,
   output logic [tpr_pkg::RGB_W-1:0]                                 rsp_pixel_rgb,
   output logic                                                      rsp_last
);
   import tpr_pkg::*;

   logic [CNT_W-1:0]                          cnt_ff;
   logic [CNT_W-1:0]                          cnt_in;
   logic [PIX_PER_ITEM-1:0][COORD_BITS-1:0]   x_ff;
   logic [PIX_PER_ITEM-1:0][COORD_BITS-1:0]   x_in;
   logic [PIX_PER_ITEM-1:0][COORD_BITS-1:0]   y_ff;
   logic [PIX_PER_ITEM-1:0][COORD_BITS-1:0]   y_in;
   logic [PIX_PER_ITEM-1:0][RGB_W-1:0]        rgb_ff;
   logic [PIX_PER_ITEM-1:0][RGB_W-1:0]        rgb_in;
   logic                                      pop;

   assign rsp_valid = (cnt_ff != '0);
   assign pop       = rsp_valid & ~rsp_stall;
   assign ready     = (cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && pop);

   always_comb begin
      cnt_in = cnt_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      rgb_in = rgb_ff;
      if (load) begin
         cnt_in = in_cnt;
         x_in   = in_x;
         y_in   = in_y;
         rgb_in = in_rgb;
      end else if (pop) begin
         // advance the next write into the head slot
         cnt_in = cnt_ff - CNT_W'(1);
         for (int i = 0; i < PIX_PER_ITEM - 1; i++) begin
            x_in[i]   = x_ff[i + 1];
            y_in[i]   = y_ff[i + 1];
            rgb_in[i] = rgb_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      rgb_ff <= rgb_in;
   end

   assign rsp_pixel_x   = x_ff[0];
   assign rsp_pixel_y   = y_ff[0];
   assign rsp_pixel_rgb = rgb_ff[0];
   assign rsp_last      = (cnt_ff == CNT_W'(1));

endmodule

`default_nettype wire

FILE: rtl/tpr_checker.sv
// ----------------------------------------------------------------------------
// Tile pixel render checker
// Port-level checks on the request and result channels of the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tile_pixel_render_2bpp_top_defines.svh"

module tpr_checker #(
   parameter int COORD_BITS = tpr_pkg::COORD_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_stall,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   input  wire logic [COORD_BITS-1:0]      rsp_pixel_x,
   input  wire logic [COORD_BITS-1:0]      rsp_pixel_y,
   input  wire logic [tpr_pkg::RGB_W-1:0]  rsp_pixel_rgb,
   input  wire logic                       rsp_last
);

   `TPR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_pixel_y) && $stable(rsp_pixel_rgb) && $stable(rsp_last))
   `TPR_ASSERT_NEXT(a_burst_unbroken, rsp_valid && !rsp_stall && !rsp_last, rsp_valid)
   `TPR_ASSERT_NOW(a_stall_needs_result, req_stall, rsp_valid)
   `TPR_ASSERT_NEXT_ALWAYS(a_reset_quiet, reset, !rsp_valid)

endmodule

bind tile_pixel_render_2bpp_top tpr_checker #(
   .COORD_BITS (COORD_BITS)
) u_tpr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_pixel_x   (rsp_pixel_x),
   .rsp_pixel_y   (rsp_pixel_y),
   .rsp_pixel_rgb (rsp_pixel_rgb),
   .rsp_last      (rsp_last)
);

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Tile pixel render testbench
// Drives packed tile bytes through directed and random tests across several
// register settings. A local predictor works out the flipped, clipped and
// palette-colored pixel writes of each accepted item, and a checker compares
// every accepted write with the oldest pending one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import tpr_pkg::*;

   localparam int CW         = COORD_BITS_DEF;
   localparam int DRAIN_WAIT = 8;
   localparam int STUCK_MAX  = 2000;

   typedef struct {
      logic [DATA_W-1:0]  data;
      logic [ROW_W-1:0]   row;
      logic [GROUP_W-1:0] grp;
      logic [CW-1:0]      x;
      logic [CW-1:0]      y;
      logic               fx;
      logic               fy;
      logic               mask;
   } tile_byte_type;

   typedef struct {
      logic [CW-1:0]    x;
      logic [CW-1:0]    y;
      logic [RGB_W-1:0] rgb;
      logic             last;
   } pixel_write_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [DATA_W-1:0]      req_data_byte;
   logic [ROW_W-1:0]       req_tile_row;
   logic [GROUP_W-1:0]     req_column_group;
   logic [CW-1:0]          req_tile_x;
   logic [CW-1:0]          req_tile_y;
   logic                   req_flip_x;
   logic                   req_flip_y;
   logic                   req_mask_enable;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [CW-1:0]          rsp_pixel_x;
   logic [CW-1:0]          rsp_pixel_y;
   logic [RGB_W-1:0]       rsp_pixel_rgb;
   logic                   rsp_last;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   logic [TILE_SIZE_W-1:0] cur_size_code;
   logic [SCREEN_W-1:0]    cur_width;
   logic [SCREEN_W-1:0]    cur_height;
   logic [COLOR_W-1:0]     cur_palette [NUM_COLORS];

   pixel_write_type pixel_q [$];
   pixel_write_type want_px;
   int              errors = 0;
   int              stuck_cycles = 0;
   int              send_gap_pct;
   int              stall_pct;

   tile_pixel_render_2bpp_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_tile_row     (req_tile_row),
      .req_column_group (req_column_group),
      .req_tile_x       (req_tile_x),
      .req_tile_y       (req_tile_y),
      .req_flip_x       (req_flip_x),
      .req_flip_y       (req_flip_y),
      .req_mask_enable  (req_mask_enable),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_rgb    (rsp_pixel_rgb),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      while (stuck_cycles < STUCK_MAX) @(posedge clock);
      $display("%0t: no progress for %0d cycles", $time, STUCK_MAX);
      $display("TB_ERROR");
      $finish;
   end

   function automatic int unsigned tile_edge();
      int unsigned s;
      s = int'(cur_size_code & 5'h1C);
      if (s > MAX_TILE_SIZE) begin
         s = MAX_TILE_SIZE;
      end
      if (s == 0) begin
         s = 4;
      end
      return s;
   endfunction

   function automatic tile_byte_type make_byte(input int data, input int row, input int grp,
                                               input int x, input int y, input bit fx,
                                               input bit fy, input bit mask);
      tile_byte_type b;
      b.data = DATA_W'(data);
      b.row  = ROW_W'(row);
      b.grp  = GROUP_W'(grp);
      b.x    = CW'(x);
      b.y    = CW'(y);
      b.fx   = fx;
      b.fy   = fy;
      b.mask = mask;
      return b;
   endfunction

   // pixel writes that one tile byte yields under the current registers
   task automatic predict_pixels(input tile_byte_type b);
      pixel_write_type px [4];
      int unsigned     tsz;
      int unsigned     yy;
      int unsigned     xx;
      int unsigned     mx;
      logic [1:0]      cidx;
      logic [31:0]     col;
      int              n;
      tsz = tile_edge();
      n   = 0;
      if (int'(b.row) >= tsz || int'(b.grp) * 4 >= tsz) return;
      if (int'(b.x) >= int'(cur_width) || int'(b.y) >= int'(cur_height)) return;
      yy = b.fy ? int'(b.y) + tsz - int'(b.row) - 1 : int'(b.y) + int'(b.row);
      if (yy >= cur_height || yy >= (1 << CW)) return;
      for (int k = 0; k < 4; k++) begin
         mx = int'(b.grp) * 4 + k;
         xx = b.fx ? int'(b.x) + tsz - mx - 1 : int'(b.x) + mx;
         if (xx >= cur_width || xx >= (1 << CW)) continue;
         cidx = {b.data[7-k], b.data[3-k]};
         col  = cur_palette[cidx];
         if (b.mask && col[31:24] == 8'h00) continue;
         px[n].x    = xx[CW-1:0];
         px[n].y    = yy[CW-1:0];
         px[n].rgb  = col[RGB_W-1:0];
         px[n].last = 1'b0;
         n++;
      end
      if (n > 0) begin
         px[n-1].last = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
         pixel_q.insert(pixel_q.size(), px[i]);
      end
   endtask

   task automatic check_field(input string name, input logic [RGB_W-1:0] want,
                              input logic [RGB_W-1:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected pixel write, expected none, actual x=%0d y=%0d",
                     $time, rsp_pixel_x, rsp_pixel_y);
         end else begin
            want_px = pixel_q.pop_front();
            check_field("pixel_x", RGB_W'(want_px.x), RGB_W'(rsp_pixel_x));
            check_field("pixel_y", RGB_W'(want_px.y), RGB_W'(rsp_pixel_y));
            check_field("pixel_rgb", want_px.rgb, rsp_pixel_rgb);
            check_field("last", RGB_W'(want_px.last), RGB_W'(rsp_last));
         end
      end
   end

   task automatic send_tile_byte(input tile_byte_type b);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data_byte    <= b.data;
      req_tile_row     <= b.row;
      req_column_group <= b.grp;
      req_tile_x       <= b.x;
      req_tile_y       <= b.y;
      req_flip_x       <= b.fx;
      req_flip_y       <= b.fy;
      req_mask_enable  <= b.mask;
      req_valid        <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_pixels(b);
   endtask

   // hold the input idle until every pending write is out
   task automatic wait_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TILE_SIZE:     cur_size_code = value[TILE_SIZE_W-1:0];
         CSR_SCREEN_WIDTH:  cur_width = value[SCREEN_W-1:0];
         CSR_SCREEN_HEIGHT: cur_height = value[SCREEN_W-1:0];
         CSR_PALETTE_0:     cur_palette[0] = value;
         CSR_PALETTE_1:     cur_palette[1] = value;
         CSR_PALETTE_2:     cur_palette[2] = value;
         CSR_PALETTE_3:     cur_palette[3] = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_palette(input logic [31:0] c0, input logic [31:0] c1,
                              input logic [31:0] c2, input logic [31:0] c3);
      write_reg(CSR_PALETTE_0, c0);
      write_reg(CSR_PALETTE_1, c1);
      write_reg(CSR_PALETTE_2, c2);
      write_reg(CSR_PALETTE_3, c3);
   endtask

   task automatic set_screen(input int tsz_code, input int width, input int height);
      write_reg(CSR_TILE_SIZE, tsz_code);
      write_reg(CSR_SCREEN_WIDTH, width);
      write_reg(CSR_SCREEN_HEIGHT, height);
   endtask

   task automatic test_register_defaults();
      send_tile_byte(make_byte(8'hA5, 0, 0, 0, 0, 0, 0, 0));
      send_tile_byte(make_byte(8'hFF, 7, 1, 255, 223, 1, 1, 0));
      send_tile_byte(make_byte(8'h3C, 8, 2, 10, 10, 0, 0, 0));
      send_tile_byte(make_byte(8'h5A, 3, 0, 20, 30, 0, 1, 1));
      wait_drain();
   endtask

   task automatic test_palette_mask();
      set_palette(32'h00_123456, 32'hFF_ABCDEF, 32'h00_FFFFFF, 32'h01_000000);
      send_tile_byte(make_byte(8'h00, 2, 0, 40, 40, 0, 0, 1));
      send_tile_byte(make_byte(8'hF0, 2, 1, 40, 40, 0, 0, 1));
      send_tile_byte(make_byte(8'h0F, 5, 1, 40, 40, 1, 0, 0));
      send_tile_byte(make_byte(8'h5A, 6, 0, 40, 40, 0, 1, 1));
      wait_drain();
   endtask

   task automatic test_tile_size_rounding();
      set_palette(32'hFF_000001, 32'h80_000010, 32'h40_000100, 32'h20_001000);
      write_reg(CSR_TILE_SIZE, 0);
      send_tile_byte(make_byte(8'h93, 3, 0, 100, 100, 1, 1, 0));
      send_tile_byte(make_byte(8'hFF, 4, 0, 100, 100, 0, 0, 0));
      send_tile_byte(make_byte(8'hFF, 0, 1, 100, 100, 0, 0, 0));
      wait_drain();
      write_reg(CSR_TILE_SIZE, 31);
      send_tile_byte(make_byte(8'h6C, 15, 3, 100, 100, 1, 0, 0));
      wait_drain();
      write_reg(CSR_TILE_SIZE, 5);
      send_tile_byte(make_byte(8'hC6, 0, 0, 100, 100, 1, 1, 0));
      wait_drain();
      write_reg(CSR_TILE_SIZE, 12);
      send_tile_byte(make_byte(8'h39, 11, 2, 100, 100, 0, 1, 0));
      send_tile_byte(make_byte(8'h39, 11, 3, 100, 100, 0, 1, 0));
      wait_drain();
   endtask

   task automatic test_clip_and_overflow();
      set_screen(4, 10, 5);
      send_tile_byte(make_byte(8'hFF, 0, 0, 8, 4, 0, 0, 0));
      send_tile_byte(make_byte(8'hE4, 3, 0, 8, 4, 0, 1, 0));
      send_tile_byte(make_byte(8'hFF, 0, 0, 10, 0, 0, 0, 0));
      wait_drain();
      set_screen(4, 1, 1);
      send_tile_byte(make_byte(8'hB1, 0, 0, 0, 0, 0, 0, 0));
      send_tile_byte(make_byte(8'hB1, 3, 0, 0, 0, 1, 1, 0));
      wait_drain();
      write_reg(CSR_SCREEN_WIDTH, 0);
      send_tile_byte(make_byte(8'hFF, 0, 0, 0, 0, 0, 0, 0));
      wait_drain();
      set_screen(16, 4096, 4096);
      send_tile_byte(make_byte(8'h77, 15, 3, 4095, 4095, 1, 1, 0));
      send_tile_byte(make_byte(8'hD2, 0, 0, 4094, 4095, 0, 0, 0));
      send_tile_byte(make_byte(8'hD2, 1, 0, 4000, 4095, 0, 0, 0));
      wait_drain();
   endtask

   function automatic tile_byte_type random_tile_byte();
      tile_byte_type b;
      int unsigned   tsz;
      int unsigned   xmax;
      int unsigned   ymax;
      tsz    = tile_edge();
      b.data = DATA_W'($urandom_range(255));
      b.fx   = 1'($urandom_range(1));
      b.fy   = 1'($urandom_range(1));
      b.mask = 1'($urandom_range(1));
      if ($urandom_range(99) < 80) begin
         xmax = (cur_width > 4096) ? 4095 : int'(cur_width) - 1;
         ymax = (cur_height > 4096) ? 4095 : int'(cur_height) - 1;
         b.row = ROW_W'($urandom_range(tsz - 1));
         b.grp = GROUP_W'($urandom_range(tsz / 4 - 1));
         b.x   = CW'($urandom_range(xmax));
         b.y   = CW'($urandom_range(ymax));
      end else begin
         b.row = ROW_W'($urandom_range(15));
         b.grp = GROUP_W'($urandom_range(3));
         b.x   = CW'($urandom_range(4095));
         b.y   = CW'($urandom_range(4095));
      end
      return b;
   endfunction

   task automatic test_random_traffic(input int gap_pct, input int stall, input int tsz_code,
                                      input int width, input int height, input int n_items);
      logic [31:0] c [4];
      for (int i = 0; i < 4; i++) begin
         c[i] = $urandom();
         if ($urandom_range(99) < 30) c[i][31:24] = 8'h00;
      end
      set_screen(tsz_code, width, height);
      set_palette(c[0], c[1], c[2], c[3]);
      send_gap_pct = gap_pct;
      stall_pct    = stall;
      for (int i = 0; i < n_items; i++) begin
         if (i == n_items / 2) wait_drain();
         send_tile_byte(random_tile_byte());
      end
      wait_drain();
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data_byte    = '0;
      req_tile_row     = '0;
      req_column_group = '0;
      req_tile_x       = '0;
      req_tile_y       = '0;
      req_flip_x       = 1'b0;
      req_flip_y       = 1'b0;
      req_mask_enable  = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = CSR_TILE_SIZE;
      csr_wdata        = '0;
      send_gap_pct     = 21;
      stall_pct        = 78;
      cur_size_code    = TILE_SIZE_RST;
      cur_width        = SCREEN_WIDTH_RST;
      cur_height       = SCREEN_HEIGHT_RST;
      for (int i = 0; i < NUM_COLORS; i++) cur_palette[i] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_defaults();
      test_palette_mask();
      test_tile_size_rounding();
      test_clip_and_overflow();
      test_random_traffic(21, 78, 8, 256, 224, 84);
      test_random_traffic(78, 21, 16, 4096, 4096, 84);
      test_random_traffic(0, 0, $urandom_range(31), $urandom_range(300, 1),
                          $urandom_range(300, 1), 84);

      wait_drain();
      if (errors == 0 && pixel_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
